### hw/rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg: cluster chain engine definitions
// Table geometry, command and status codes, chain markers and register
// indexes shared by the cluster chain engine.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam logic [16:0] TABLE_LEN = 17'(TABLE_ENTRIES);

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WORD_W-1:0]   word_t;

    localparam func_t FN_WRITE      = 3'd0;
    localparam func_t FN_READ       = 3'd1;
    localparam func_t FN_FIRST_FREE = 3'd2;
    localparam func_t FN_FREE_RUN   = 3'd3;
    localparam func_t FN_LAST       = 3'd4;
    localparam func_t FN_FREE_CHAIN = 3'd5;
    localparam func_t FN_APPEND     = 3'd6;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FAIL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam word_t SMALL_LIMIT = 16'h0ff0;
    localparam word_t SMALL_MARK  = 16'h0fff;
    localparam word_t LARGE_LIMIT = 16'hfff0;
    localparam word_t LARGE_MARK  = 16'hffff;

    localparam word_t CLUSTER_END_RST = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_TABLE = 1'b1;

endpackage

### hw/rtl/fat_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine: FAT12/FAT16 cluster link table
// Holds the link table in a one-write, one-read memory and runs each command
// under a small sequencer that reuses one read port and one comparator path.
// ----------------------------------------------------------------------------
// Usage
//   Command items enter on in_valid/in_ready (func, cluster, entry_value,
//   run_length); one result item (status, result_value) leaves on
//   out_valid/out_ready for every command. in_ready is high only while the
//   sequencer is idle; one command is worked on at a time.
//   Every table probe or link step goes through the single registered memory
//   read port, with its address and its data in separate states (a test
//   state and a check state), so the time per item grows with the entries
//   scanned, the links walked and, for free run, the restarts; a free run
//   whose length is refused ends without any table read.
//   The result sits in an output register; the next command is taken while
//   it waits. If a new result is ready before the old one is taken, the
//   sequencer holds it until out_ready frees the register.
//   Reset clears the sequencer, the output valid and the registers
//   (cluster_end 4096, large_table 0). The table is not cleared: entries
//   are undefined until written. Write registers via cfg_we only while idle.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcc_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fcc_pkg::FUNC_W-1:0]   func,
    input  logic [fcc_pkg::WORD_W-1:0]   cluster,
    input  logic [fcc_pkg::WORD_W-1:0]   entry_value,
    input  logic [fcc_pkg::WORD_W-1:0]   run_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fcc_pkg::STATUS_W-1:0] status,
    output logic [fcc_pkg::WORD_W-1:0]   result_value
);
    import fcc_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_RD_CHK    = 4'd2;
    localparam logic [3:0] S_WALK_TEST = 4'd3;
    localparam logic [3:0] S_WALK_CHK  = 4'd4;
    localparam logic [3:0] S_FF_TEST   = 4'd5;
    localparam logic [3:0] S_FF_CHK    = 4'd6;
    localparam logic [3:0] S_APP_LINK  = 4'd7;
    localparam logic [3:0] S_RUN_WIN   = 4'd8;
    localparam logic [3:0] S_RUN_TEST  = 4'd9;
    localparam logic [3:0] S_RUN_CHK   = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    // configuration
    word_t  cluster_end_reg;
    logic   large_table_reg;

    // sequencer
    logic [3:0]       state_reg, state_next;
    func_t            func_reg, func_next;
    word_t            cl_reg, cl_next;
    word_t            val_reg, val_next;
    word_t            run_reg, run_next;
    word_t            cur_reg, cur_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic             prev_ok_reg, prev_ok_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] k_reg, k_next;
    status_t          st_reg, st_next;
    word_t            res_reg, res_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    word_t   result_reg, result_next;

    // table memory
    word_t            link_mem [TABLE_ENTRIES];
    word_t            rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    word_t            wdata;

    // derived values
    logic [16:0]      lim_wide;
    logic [CNT_W-1:0] search_lim;
    word_t            chain_lim;
    word_t            marker;
    logic [CNT_W-1:0] run_cnt;
    logic [CNT_W-1:0] probe;
    logic [CNT_W:0]   window_end;
    logic             cl_in_table;
    logic             cur_in_table;
    logic             cur_is_link;
    logic             steps_full;

    always_comb
    begin
        lim_wide     = ({1'b0, cluster_end_reg} > TABLE_LEN) ? TABLE_LEN
                                                             : {1'b0, cluster_end_reg};
        search_lim   = lim_wide[CNT_W-1:0];
        chain_lim    = large_table_reg ? LARGE_LIMIT : SMALL_LIMIT;
        marker       = large_table_reg ? LARGE_MARK : SMALL_MARK;
        run_cnt      = CNT_W'(run_reg);
        probe        = s_reg + k_reg;
        window_end   = {1'b0, s_reg} + {1'b0, run_cnt};
        cl_in_table  = {1'b0, cl_reg} < TABLE_LEN;
        cur_in_table = {1'b0, cur_reg} < TABLE_LEN;
        cur_is_link  = (cur_reg != '0) && (cur_reg < chain_lim);
        steps_full   = 17'(steps_reg) >= TABLE_LEN;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        cl_next        = cl_reg;
        val_next       = val_reg;
        run_next       = run_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        prev_next      = prev_reg;
        prev_ok_next   = prev_ok_reg;
        idx_next       = idx_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        result_next    = result_reg;
        rd_addr        = cl_reg[IDX_W-1:0];
        we             = 1'b0;
        waddr          = cl_reg[IDX_W-1:0];
        wdata          = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    cl_next    = cluster;
                    val_next   = entry_value;
                    run_next   = run_length;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                st_next      = ST_FAIL;
                res_next     = '0;
                cur_next     = cl_reg;
                steps_next   = '0;
                prev_next    = '0;
                prev_ok_next = 1'b0;
                idx_next     = CNT_W'(2);
                s_next       = CNT_W'(2);
                k_next       = '0;
                state_next   = S_DONE;
                case (func_reg)
                    FN_WRITE:
                    begin
                        if (cl_in_table)
                        begin
                            we      = 1'b1;
                            st_next = ST_OK;
                        end
                        else
                            st_next = ST_RANGE;
                    end
                    FN_READ:
                    begin
                        if (cl_in_table)
                            state_next = S_RD_CHK;
                        else
                            st_next = ST_RANGE;
                    end
                    FN_FIRST_FREE:
                        state_next = S_FF_TEST;
                    FN_FREE_RUN:
                    begin
                        if (run_reg != '0 && {1'b0, run_reg} < 17'(search_lim))
                            state_next = S_RUN_WIN;
                    end
                    FN_LAST, FN_FREE_CHAIN, FN_APPEND:
                        state_next = S_WALK_TEST;
                    default:
                        state_next = S_DONE;
                endcase
            end

            S_RD_CHK:
            begin
                st_next    = ST_OK;
                res_next   = rdata_reg;
                state_next = S_DONE;
            end

            S_WALK_TEST:
            begin
                rd_addr = cur_reg[IDX_W-1:0];
                if (cur_is_link)
                begin
                    if (!cur_in_table || steps_full)
                    begin
                        st_next    = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        steps_next   = steps_reg + 1'b1;
                        prev_next    = cur_reg[IDX_W-1:0];
                        prev_ok_next = 1'b1;
                        state_next   = S_WALK_CHK;
                    end
                end
                else if (func_reg == FN_FREE_CHAIN)
                begin
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else if (!prev_ok_reg || cur_reg != marker)
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
                else if (func_reg == FN_LAST)
                begin
                    st_next    = ST_OK;
                    res_next   = WORD_W'(prev_reg);
                    state_next = S_DONE;
                end
                else
                    state_next = S_FF_TEST;
            end

            S_WALK_CHK:
            begin
                cur_next = rdata_reg;
                // free chain clears each link as it passes
                if (func_reg == FN_FREE_CHAIN)
                begin
                    we    = 1'b1;
                    waddr = prev_reg;
                    wdata = '0;
                end
                state_next = S_WALK_TEST;
            end

            S_FF_TEST:
            begin
                rd_addr = idx_reg[IDX_W-1:0];
                if (idx_reg < search_lim)
                    state_next = S_FF_CHK;
                else
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
            end

            S_FF_CHK:
            begin
                if (rdata_reg == '0)
                begin
                    res_next = WORD_W'(idx_reg);
                    if (func_reg == FN_APPEND)
                    begin
                        we         = 1'b1;
                        waddr      = idx_reg[IDX_W-1:0];
                        wdata      = marker;
                        state_next = S_APP_LINK;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FF_TEST;
                end
            end

            S_APP_LINK:
            begin
                we         = 1'b1;
                waddr      = prev_reg;
                wdata      = WORD_W'(idx_reg);
                st_next    = ST_OK;
                state_next = S_DONE;
            end

            S_RUN_WIN:
            begin
                if (window_end < {1'b0, search_lim})
                    state_next = S_RUN_TEST;
                else
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
            end

            S_RUN_TEST:
            begin
                rd_addr = probe[IDX_W-1:0];
                if (k_reg == run_cnt)
                begin
                    st_next    = ST_OK;
                    res_next   = WORD_W'(s_reg);
                    state_next = S_DONE;
                end
                else
                    state_next = S_RUN_CHK;
            end

            S_RUN_CHK:
            begin
                if (rdata_reg == '0)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RUN_TEST;
                end
                else
                begin
                    // restart past the used cluster
                    s_next     = probe + 1'b1;
                    k_next     = '0;
                    state_next = S_RUN_WIN;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    result_next    = (st_reg == ST_OK) ? res_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            cluster_end_reg <= CLUSTER_END_RST;
            large_table_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLUSTER_END: cluster_end_reg <= cfg_wdata;
                    CFG_LARGE_TABLE: large_table_reg <= cfg_wdata[0];
                    default:         large_table_reg <= large_table_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        cl_reg      <= cl_next;
        val_reg     <= val_next;
        run_reg     <= run_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        prev_reg    <= prev_next;
        prev_ok_reg <= prev_ok_next;
        idx_reg     <= idx_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            link_mem[waddr] <= wdata;
        rdata_reg <= link_mem[rd_addr];
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("engine took a second item while busy");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_value == '0)
        else $error("non-zero result with failing status");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> !in_ready)
        else $error("table written while idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_FAIL || status == ST_RANGE))
        else $error("undefined status code");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK_CHK |-> 17'(steps_reg) <= TABLE_LEN)
        else $error("chain walk passed the step bound");

endmodule
